// ===== rtl/core/i2cm_pkg.sv =====
// Package: shared types and constants for the I2C register access master
`timescale 1ns / 1ps
`default_nettype none
package i2cm_pkg;
   typedef enum logic [3:0] {
      PH_IDLE, PH_START_WAIT, PH_START_D1, PH_START_D2, PH_START_D3,
      PH_BIT_D1, PH_BIT_WAIT, PH_BIT_D2, PH_BIT_D3,
      PH_STOP_D1, PH_STOP_WAIT, PH_STOP_D2, PH_STOP_D3,
      PH_REC_HIGH, PH_REC_LOW, PH_REC_WAIT
   } phase_type;

   typedef enum logic [2:0] {
      SG_INIT, SG_ADDR_W, SG_REG, SG_WDATA, SG_RESTART, SG_ADDR_R, SG_RDATA
   } stage_type;

   localparam logic [1:0] OP_PROBE   = 2'd0;
   localparam logic [1:0] OP_WRITE   = 2'd1;
   localparam logic [1:0] OP_READ    = 2'd2;
   localparam logic [1:0] OP_RECOVER = 2'd3;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NACK    = 3'd1;
   localparam logic [2:0] ST_TIMEOUT = 3'd2;
   localparam logic [2:0] ST_INVALID = 3'd3;
   localparam logic [2:0] ST_STUCK   = 3'd4;
   localparam logic [2:0] ST_NOINIT  = 3'd5;

   localparam logic [1:0] CSR_ENABLE  = 2'd0;
   localparam logic [1:0] CSR_HALF    = 2'd1;
   localparam logic [1:0] CSR_STRETCH = 2'd2;

   localparam logic [6:0] ADDR_MIN = 7'h08;
   localparam logic [6:0] ADDR_MAX = 7'h77;
   localparam logic [3:0] ACK_BIT  = 4'd8;

   typedef struct packed {
      logic        command_valid;
      logic [1:0]  operation;
      logic [6:0]  target_address;
      logic [7:0]  register_index;
      logic [15:0] byte_count;
      logic [7:0]  write_data;
      logic        scl_in;
      logic        sda_in;
   } req_type;

   typedef struct packed {
      logic        scl_low;
      logic        sda_low;
      logic        tx_taken;
      logic [7:0]  rx_data;
      logic        rx_valid;
      logic        rx_last;
      logic        busy_res;
      logic        done_res;
      logic [2:0]  status;
      logic        scl_level;
      logic        sda_level;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  index;
      logic [15:0] data;
   } csr_type;
endpackage
`default_nettype wire

// ===== rtl/core/i2cm_if.sv =====
// Interfaces: valid/ready channels for request, response and register writes
`timescale 1ns / 1ps
`default_nettype none
interface i2cm_req_if;
   logic valid;
   logic ready;
   i2cm_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface i2cm_rsp_if;
   logic valid;
   logic ready;
   i2cm_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface i2cm_csr_if;
   logic valid;
   logic ready;
   i2cm_pkg::csr_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/i2c_master_register_access.sv =====
// Top level: I2C master sequencer, one bus tick per request word
//
// Each request word is one tick: sampled SCL/SDA plus an optional command
// (probe, register write, register read, bus recovery). Each accepted word
// yields exactly one response word with the line drives, tx_taken,
// received byte, busy, done and status after that tick.
// Latency: the response for a word is presented the cycle after it is
// accepted. Throughput: one word per cycle; the state step is a single
// pass of logic from the held state to the next state register.
// A one-entry response register parts the channels: req_ready is high
// whenever that register is empty or being taken this cycle, so when the
// receiver stalls the block holds its state and stops accepting.
// Register writes on the csr channel are always accepted; write them only
// while no command is running. Index 0 enable, 1 half period ticks,
// 2 stretch timeout ticks.
// Reset (synchronous, high) returns the sequencer to idle with both lines
// released, enable cleared and the timers at 250 and 1000 ticks.
`timescale 1ns / 1ps
`default_nettype none
module i2c_master_register_access #(
   parameter int RECOVERY_PULSES = 9,
   parameter int TIMER_WIDTH = 16
) (
   input wire logic clock,
   input wire logic reset,
   i2cm_req_if.sink req,
   i2cm_rsp_if.source rsp,
   i2cm_csr_if.sink csr
);
   localparam int TW = TIMER_WIDTH;

   logic              enable_ff;
   logic [15:0]       half_ff, stretch_ff;
   i2cm_pkg::phase_type phase_ff, phase_in;
   i2cm_pkg::stage_type stage_ff, stage_in;
   logic [1:0]        op_ff, op_in;
   logic [6:0]        addr_ff, addr_in;
   logic [7:0]        reg_ff, reg_in;
   logic [15:0]       left_ff, left_in;
   logic [7:0]        shift_ff, shift_in;
   logic [3:0]        bit_ff, bit_in;
   logic [TW-1:0]     hcount_ff, hcount_in;
   logic [TW-1:0]     tcount_ff, tcount_in;
   logic [3:0]        pulse_ff, pulse_in;
   logic [2:0]        fstat_ff, fstat_in;
   logic              scl_ff, scl_in_n, sda_ff, sda_in_n, nack_ff, nack_in;
   logic              rsp_valid_ff;
   i2cm_pkg::rsp_type rsp_ff, rsp_in;
   logic              step;
   i2cm_pkg::req_type r;

   logic [TW-1:0] half_t, stretch_t;
   assign half_t    = TW'(half_ff);
   assign stretch_t = TW'(stretch_ff);

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign step      = req.valid && req.ready;
   assign csr.ready = 1'b1;
   assign r         = req.data;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         half_ff    <= 16'd250;
         stretch_ff <= 16'd1000;
      end else if (csr.valid) begin
         unique case (csr.data.index)
            i2cm_pkg::CSR_ENABLE:  enable_ff  <= csr.data.data[0];
            i2cm_pkg::CSR_HALF:    half_ff    <= csr.data.data;
            i2cm_pkg::CSR_STRETCH: stretch_ff <= csr.data.data;
            default: ;
         endcase
      end
   end

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= i2cm_pkg::PH_IDLE;
         stage_ff <= i2cm_pkg::SG_INIT;
         op_ff <= '0; addr_ff <= '0; reg_ff <= '0; left_ff <= '0;
         shift_ff <= '0; bit_ff <= '0; hcount_ff <= '0; tcount_ff <= '0;
         pulse_ff <= '0; fstat_ff <= '0;
         scl_ff <= 1'b0; sda_ff <= 1'b0; nack_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            phase_ff <= phase_in; stage_ff <= stage_in;
            op_ff <= op_in; addr_ff <= addr_in; reg_ff <= reg_in;
            left_ff <= left_in; shift_ff <= shift_in; bit_ff <= bit_in;
            hcount_ff <= hcount_in; tcount_ff <= tcount_in;
            pulse_ff <= pulse_in; fstat_ff <= fstat_in;
            scl_ff <= scl_in_n; sda_ff <= sda_in_n; nack_ff <= nack_in;
         end
         if (step) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Response word holds until taken
   always_ff @(posedge clock) begin
      if (step) rsp_ff <= rsp_in;
   end

   // Next state for one tick
   always_comb begin
      logic dly_over;
      logic [7:0] sh;
      logic [15:0] lft;
      phase_in = phase_ff; stage_in = stage_ff; op_in = op_ff;
      addr_in = addr_ff; reg_in = reg_ff; left_in = left_ff;
      shift_in = shift_ff; bit_in = bit_ff; hcount_in = hcount_ff;
      tcount_in = tcount_ff; pulse_in = pulse_ff; fstat_in = fstat_ff;
      scl_in_n = scl_ff; sda_in_n = sda_ff; nack_in = nack_ff;
      rsp_in = '0;
      rsp_in.scl_level = r.scl_in;
      rsp_in.sda_level = r.sda_in;
      dly_over = (hcount_ff <= TW'(1));
      if (!dly_over) hcount_in = hcount_ff - TW'(1);
      sh = 8'd0;
      lft = 16'd0;

      unique case (phase_ff)
         i2cm_pkg::PH_IDLE: begin
            if (r.command_valid) begin
               if (r.operation == i2cm_pkg::OP_RECOVER) begin
                  if (!enable_ff) begin
                     rsp_in.done_res = 1'b1;
                     rsp_in.status = i2cm_pkg::ST_NOINIT;
                  end else begin
                     op_in = i2cm_pkg::OP_RECOVER;
                     scl_in_n = 1'b0; sda_in_n = 1'b0;
                     pulse_in = '0; fstat_in = i2cm_pkg::ST_OK;
                     hcount_in = half_t;
                     phase_in = i2cm_pkg::PH_REC_HIGH;
                  end
               end else if (!enable_ff || r.target_address < i2cm_pkg::ADDR_MIN ||
                            r.target_address > i2cm_pkg::ADDR_MAX ||
                            (r.operation != i2cm_pkg::OP_PROBE && r.byte_count == 16'd0)) begin
                  rsp_in.done_res = 1'b1;
                  rsp_in.status = i2cm_pkg::ST_INVALID;
               end else begin
                  op_in = r.operation; addr_in = r.target_address;
                  reg_in = r.register_index; left_in = r.byte_count;
                  fstat_in = i2cm_pkg::ST_OK; nack_in = 1'b0;
                  stage_in = i2cm_pkg::SG_INIT;
                  sda_in_n = 1'b0; scl_in_n = 1'b0;
                  tcount_in = stretch_t;
                  phase_in = i2cm_pkg::PH_START_WAIT;
               end
            end
         end
         i2cm_pkg::PH_START_WAIT, i2cm_pkg::PH_BIT_WAIT,
         i2cm_pkg::PH_STOP_WAIT, i2cm_pkg::PH_REC_WAIT: begin
            if (r.scl_in) begin
               hcount_in = half_t;
               unique case (phase_ff)
                  i2cm_pkg::PH_START_WAIT: phase_in = i2cm_pkg::PH_START_D1;
                  i2cm_pkg::PH_BIT_WAIT:   phase_in = i2cm_pkg::PH_BIT_D2;
                  i2cm_pkg::PH_STOP_WAIT:  phase_in = i2cm_pkg::PH_STOP_D2;
                  default:                 phase_in = i2cm_pkg::PH_REC_HIGH;
               endcase
            end else if (tcount_ff != '0) begin
               hcount_in = hcount_ff;
               tcount_in = tcount_ff - TW'(1);
            end else begin
               hcount_in = hcount_ff;
               priority case (phase_ff)
                  i2cm_pkg::PH_REC_WAIT: begin
                     hcount_in = half_t; phase_in = i2cm_pkg::PH_REC_HIGH;
                  end
                  i2cm_pkg::PH_START_WAIT: begin
                     if (stage_ff == i2cm_pkg::SG_RESTART) begin
                        fstat_in = i2cm_pkg::ST_TIMEOUT; sda_in_n = 1'b1;
                        hcount_in = half_t; phase_in = i2cm_pkg::PH_STOP_D1;
                     end else begin
                        phase_in = i2cm_pkg::PH_IDLE; rsp_in.done_res = 1'b1;
                        rsp_in.status = i2cm_pkg::ST_TIMEOUT;
                     end
                  end
                  i2cm_pkg::PH_BIT_WAIT: begin
                     fstat_in = i2cm_pkg::ST_TIMEOUT; sda_in_n = 1'b1;
                     hcount_in = half_t; phase_in = i2cm_pkg::PH_STOP_D1;
                  end
                  default: begin
                     phase_in = i2cm_pkg::PH_IDLE; rsp_in.done_res = 1'b1;
                     if (op_ff == i2cm_pkg::OP_RECOVER)
                        rsp_in.status = (r.scl_in && r.sda_in) ? i2cm_pkg::ST_OK
                                                               : i2cm_pkg::ST_STUCK;
                     else if (fstat_ff == i2cm_pkg::ST_OK)
                        rsp_in.status = i2cm_pkg::ST_TIMEOUT;
                     else rsp_in.status = fstat_ff;
                  end
               endcase
            end
         end
         i2cm_pkg::PH_START_D1: if (dly_over) begin
            sda_in_n = 1'b1; hcount_in = half_t; phase_in = i2cm_pkg::PH_START_D2;
         end
         i2cm_pkg::PH_START_D2: if (dly_over) begin
            scl_in_n = 1'b1; hcount_in = half_t; phase_in = i2cm_pkg::PH_START_D3;
         end
         i2cm_pkg::PH_START_D3: if (dly_over) begin
            // begin address byte, first bit
            if (stage_ff == i2cm_pkg::SG_RESTART) begin
               stage_in = i2cm_pkg::SG_ADDR_R; sh = {addr_ff, 1'b1};
            end else begin
               stage_in = i2cm_pkg::SG_ADDR_W; sh = {addr_ff, 1'b0};
            end
            bit_in = '0; sda_in_n = !sh[7]; shift_in = {sh[6:0], 1'b0};
            hcount_in = half_t; phase_in = i2cm_pkg::PH_BIT_D1;
         end
         i2cm_pkg::PH_BIT_D1: if (dly_over) begin
            scl_in_n = 1'b0; tcount_in = stretch_t; phase_in = i2cm_pkg::PH_BIT_WAIT;
         end
         i2cm_pkg::PH_BIT_D2: if (dly_over) begin
            if (stage_ff == i2cm_pkg::SG_RDATA) begin
               if (bit_ff < i2cm_pkg::ACK_BIT) begin
                  shift_in = {shift_ff[6:0], r.sda_in};
                  if (bit_ff == i2cm_pkg::ACK_BIT - 4'd1) begin
                     rsp_in.rx_valid = 1'b1;
                     rsp_in.rx_data = {shift_ff[6:0], r.sda_in};
                     rsp_in.rx_last = (left_ff == 16'd1);
                  end
               end
            end else if (bit_ff == i2cm_pkg::ACK_BIT) nack_in = r.sda_in;
            scl_in_n = 1'b1; hcount_in = half_t; phase_in = i2cm_pkg::PH_BIT_D3;
         end
         i2cm_pkg::PH_BIT_D3: if (dly_over) begin
            hcount_in = half_t;
            phase_in = i2cm_pkg::PH_BIT_D1;
            if (bit_ff < i2cm_pkg::ACK_BIT) begin
               // next bit of the same byte
               bit_in = bit_ff + 4'd1;
               if (bit_in < i2cm_pkg::ACK_BIT) begin
                  if (stage_ff == i2cm_pkg::SG_RDATA) sda_in_n = 1'b0;
                  else begin
                     sda_in_n = !shift_ff[7]; shift_in = {shift_ff[6:0], 1'b0};
                  end
               end else
                  sda_in_n = (stage_ff == i2cm_pkg::SG_RDATA) && (left_ff > 16'd1);
            end else begin
               // byte finished: choose what follows
               priority if (stage_ff == i2cm_pkg::SG_RDATA) begin
                  lft = left_ff - 16'd1; left_in = lft;
                  if (lft == 16'd0) begin
                     fstat_in = i2cm_pkg::ST_OK; sda_in_n = 1'b1;
                     phase_in = i2cm_pkg::PH_STOP_D1;
                  end else begin
                     bit_in = '0; shift_in = '0; sda_in_n = 1'b0;
                  end
               end else if (nack_ff) begin
                  fstat_in = i2cm_pkg::ST_NACK; sda_in_n = 1'b1;
                  phase_in = i2cm_pkg::PH_STOP_D1;
               end else if ((stage_ff == i2cm_pkg::SG_ADDR_W &&
                             op_ff == i2cm_pkg::OP_PROBE) ||
                            (stage_ff == i2cm_pkg::SG_WDATA && left_ff == 16'd0)) begin
                  fstat_in = i2cm_pkg::ST_OK; sda_in_n = 1'b1;
                  phase_in = i2cm_pkg::PH_STOP_D1;
               end else if (stage_ff == i2cm_pkg::SG_ADDR_W) begin
                  stage_in = i2cm_pkg::SG_REG; bit_in = '0;
                  sda_in_n = !reg_ff[7]; shift_in = {reg_ff[6:0], 1'b0};
               end else if ((stage_ff == i2cm_pkg::SG_REG && op_ff == i2cm_pkg::OP_WRITE) ||
                            stage_ff == i2cm_pkg::SG_WDATA) begin
                  rsp_in.tx_taken = 1'b1; left_in = left_ff - 16'd1;
                  stage_in = i2cm_pkg::SG_WDATA; bit_in = '0;
                  sda_in_n = !r.write_data[7]; shift_in = {r.write_data[6:0], 1'b0};
               end else if (stage_ff == i2cm_pkg::SG_REG) begin
                  stage_in = i2cm_pkg::SG_RESTART;
                  sda_in_n = 1'b0; scl_in_n = 1'b0; tcount_in = stretch_t;
                  hcount_in = hcount_ff;
                  phase_in = i2cm_pkg::PH_START_WAIT;
               end else begin
                  stage_in = i2cm_pkg::SG_RDATA; bit_in = '0; shift_in = '0;
                  sda_in_n = 1'b0;
               end
            end
         end
         i2cm_pkg::PH_STOP_D1: if (dly_over) begin
            scl_in_n = 1'b0; tcount_in = stretch_t; phase_in = i2cm_pkg::PH_STOP_WAIT;
         end
         i2cm_pkg::PH_STOP_D2: if (dly_over) begin
            sda_in_n = 1'b0; hcount_in = half_t; phase_in = i2cm_pkg::PH_STOP_D3;
         end
         i2cm_pkg::PH_STOP_D3: if (dly_over) begin
            phase_in = i2cm_pkg::PH_IDLE; rsp_in.done_res = 1'b1;
            if (op_ff == i2cm_pkg::OP_RECOVER)
               rsp_in.status = (r.scl_in && r.sda_in) ? i2cm_pkg::ST_OK
                                                      : i2cm_pkg::ST_STUCK;
            else rsp_in.status = fstat_ff;
         end
         i2cm_pkg::PH_REC_HIGH: if (dly_over) begin
            if (32'(pulse_ff) < RECOVERY_PULSES) begin
               if (r.scl_in && r.sda_in) begin
                  phase_in = i2cm_pkg::PH_IDLE; rsp_in.done_res = 1'b1;
                  rsp_in.status = i2cm_pkg::ST_OK;
               end else begin
                  scl_in_n = 1'b1; pulse_in = pulse_ff + 4'd1;
                  hcount_in = half_t; phase_in = i2cm_pkg::PH_REC_LOW;
               end
            end else begin
               fstat_in = i2cm_pkg::ST_OK; sda_in_n = 1'b1;
               hcount_in = half_t; phase_in = i2cm_pkg::PH_STOP_D1;
            end
         end
         i2cm_pkg::PH_REC_LOW: if (dly_over) begin
            scl_in_n = 1'b0; tcount_in = stretch_t; phase_in = i2cm_pkg::PH_REC_WAIT;
         end
         default: phase_in = i2cm_pkg::PH_IDLE;
      endcase

      rsp_in.scl_low  = scl_in_n;
      rsp_in.sda_low  = sda_in_n;
      rsp_in.busy_res = (phase_in != i2cm_pkg::PH_IDLE);
   end

   // Checks on the sequencer
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      step && rsp_in.done_res |=> phase_ff == i2cm_pkg::PH_IDLE)
      else $error("done without return to idle");
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.done_res && rsp_ff.busy_res))
      else $error("done and busy together");
   a_pulse_bound: assert property (@(posedge clock) disable iff (reset)
      32'(pulse_ff) <= RECOVERY_PULSES)
      else $error("recovery pulse count overrun");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff))
      else $error("state moved without a word");
endmodule
`default_nettype wire
